/* rtl/core/timer_table_scheduler_core_macros.svh */
// Assertion macros for the timer table scheduler core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TIMER_TABLE_SCHEDULER_CORE_MACROS_SVH
`define TIMER_TABLE_SCHEDULER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every edge outside reset.
`define TTSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define TTSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TTSC_ASSERT(lbl, clk, rst, prop, msg)
`define TTSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/core/ttsc_pkg.sv */
// Shared types for the timer table scheduler core: operation codes,
// result status codes and controller states. No dependencies.
`default_nettype none

package ttsc_pkg;

   typedef enum logic [1:0] {
      FUNC_ADD_PERIODIC = 2'd0,
      FUNC_ADD_ONESHOT  = 2'd1,
      FUNC_DELETE       = 2'd2,
      FUNC_TICK         = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STATUS_ADDED     = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_DELETED   = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_TICK      = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_DONE = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/ttsc_cell.sv */
// One timer entry of the rotating table: active and fired flags, key,
// period and due time, handed to the next cell on every shift. No dependencies.
`default_nettype none

module ttsc_cell #(
   parameter int TIME_BITS = 32,
   parameter int KEY_BITS  = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift,
   input  wire logic                 active_in,
   input  wire logic                 fired_in,
   input  wire logic [KEY_BITS-1:0]  key_in,
   input  wire logic [TIME_BITS-1:0] period_in,
   input  wire logic [TIME_BITS-1:0] due_in,
   output logic                      active_out,
   output logic                      fired_out,
   output logic [KEY_BITS-1:0]       key_out,
   output logic [TIME_BITS-1:0]      period_out,
   output logic [TIME_BITS-1:0]      due_out
);

   logic                 active_ff;
   logic                 fired_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [TIME_BITS-1:0] period_ff;
   logic [TIME_BITS-1:0] due_ff;

   // Flags reset; the payload is only read while the entry is active or marked fired.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         fired_ff  <= 1'b0;
      end else if (shift) begin
         active_ff <= active_in;
         fired_ff  <= fired_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff    <= key_in;
         period_ff <= period_in;
         due_ff    <= due_in;
      end
   end

   assign active_out = active_ff;
   assign fired_out  = fired_ff;
   assign key_out    = key_ff;
   assign period_out = period_ff;
   assign due_out    = due_ff;

endmodule

`default_nettype wire

/* rtl/core/timer_table_scheduler_core.sv */
// Timer table scheduler: an add, a delete or a tick with nothing due makes one ring rotation,
// then loads its result word in ST_DONE and is ready for the next request. A tick that fires
// hands out its expiry words in a second rotation, after which the next request is taken; a
// word that waits on rsp_stall holds the ring (or ST_DONE) until the response register frees.
// Reset is synchronous: it clears the active flags and counters at once, no clearing pass.
`default_nettype none
`include "timer_table_scheduler_core_macros.svh"

module timer_table_scheduler_core #(
   parameter int ENTRIES   = 16,
   parameter int TIME_BITS = 32,
   parameter int KEY_BITS  = 16,
   parameter int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   parameter int CNT_BITS  = $clog2(ENTRIES + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ttsc_pkg::func_type    req_func,
   input  wire logic [TIME_BITS-1:0]  req_now,
   input  wire logic [KEY_BITS-1:0]   req_timer_key,
   input  wire logic [TIME_BITS-1:0]  req_interval,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ttsc_pkg::status_type       rsp_status,
   output logic                       rsp_fired,
   output logic [SLOT_BITS-1:0]       rsp_slot_index,
   output logic [KEY_BITS-1:0]        rsp_fired_key,
   output logic [TIME_BITS-1:0]       rsp_next_due,
   output logic                       rsp_next_valid,
   output logic [CNT_BITS-1:0]        rsp_active_count,
   output logic                       rsp_last
);

   import ttsc_pkg::*;

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(ENTRIES - 1);

   // ------------------------------------------------------------------
   // Ring of cells. The tail cell holds the slot under inspection; the
   // head logic rewrites it and feeds it back into the first cell, so
   // after ENTRIES shifts every slot is back in its resting place and
   // the shift count within a rotation equals the slot number.
   // ------------------------------------------------------------------
   logic                 chain_active [ENTRIES];
   logic                 chain_fired  [ENTRIES];
   logic [KEY_BITS-1:0]  chain_key    [ENTRIES];
   logic [TIME_BITS-1:0] chain_period [ENTRIES];
   logic [TIME_BITS-1:0] chain_due    [ENTRIES];

   logic                 head_active;
   logic                 head_fired;
   logic [KEY_BITS-1:0]  head_key;
   logic [TIME_BITS-1:0] head_period;
   logic [TIME_BITS-1:0] head_due;
   logic                 shift;

   logic                 tail_active;
   logic                 tail_fired;
   logic [KEY_BITS-1:0]  tail_key;
   logic [TIME_BITS-1:0] tail_period;
   logic [TIME_BITS-1:0] tail_due;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_first
         ttsc_cell #(.TIME_BITS(TIME_BITS), .KEY_BITS(KEY_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift      (shift),
            .active_in  (head_active),
            .fired_in   (head_fired),
            .key_in     (head_key),
            .period_in  (head_period),
            .due_in     (head_due),
            .active_out (chain_active[g]),
            .fired_out  (chain_fired[g]),
            .key_out    (chain_key[g]),
            .period_out (chain_period[g]),
            .due_out    (chain_due[g])
         );
      end else begin : g_next
         ttsc_cell #(.TIME_BITS(TIME_BITS), .KEY_BITS(KEY_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift      (shift),
            .active_in  (chain_active[g-1]),
            .fired_in   (chain_fired[g-1]),
            .key_in     (chain_key[g-1]),
            .period_in  (chain_period[g-1]),
            .due_in     (chain_due[g-1]),
            .active_out (chain_active[g]),
            .fired_out  (chain_fired[g]),
            .key_out    (chain_key[g]),
            .period_out (chain_period[g]),
            .due_out    (chain_due[g])
         );
      end
   end

   assign tail_active = chain_active[ENTRIES-1];
   assign tail_fired  = chain_fired[ENTRIES-1];
   assign tail_key    = chain_key[ENTRIES-1];
   assign tail_period = chain_period[ENTRIES-1];
   assign tail_due    = chain_due[ENTRIES-1];

   // ------------------------------------------------------------------
   // Control and request registers
   // ------------------------------------------------------------------
   state_type            state_ff,  state_in;
   logic [SLOT_BITS-1:0] cnt_ff,    cnt_in;
   logic                 found_ff,  found_in;
   logic [SLOT_BITS-1:0] slot_ff,   slot_in;
   logic                 any_ff,    any_in;
   logic [TIME_BITS-1:0] best_ff,   best_in;
   logic [CNT_BITS-1:0]  live_ff,   live_in;
   logic [CNT_BITS-1:0]  remain_ff, remain_in;
   func_type             func_ff,   func_in;
   logic [TIME_BITS-1:0] now_ff,    now_in;
   logic [KEY_BITS-1:0]  key_ff,    key_in;
   logic [TIME_BITS-1:0] ival_ff,   ival_in;

   // response word register
   logic                 rsp_valid_ff,  rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_fired_ff,  rsp_fired_in;
   logic [SLOT_BITS-1:0] rsp_slot_ff,   rsp_slot_in;
   logic [KEY_BITS-1:0]  rsp_key_ff,    rsp_key_in;
   logic [TIME_BITS-1:0] rsp_due_ff,    rsp_due_in;
   logic                 rsp_nv_ff,     rsp_nv_in;
   logic [CNT_BITS-1:0]  rsp_count_ff,  rsp_count_in;
   logic                 rsp_last_ff,   rsp_last_in;

   logic                 out_free;
   logic                 hit;
   logic                 fire;
   logic                 inc;
   logic                 dec;
   logic                 emit;
   logic [TIME_BITS-1:0] add_b;
   logic [TIME_BITS:0]   add_sum;
   logic [TIME_BITS-1:0] sat_due;

   assign req_stall = (state_ff != ST_IDLE);
   // the response register can take a word when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // One saturating adder: now + interval for an add, now + period on rearm.
   assign add_b   = (func_ff == FUNC_TICK) ? tail_period : ival_ff;
   assign add_sum = {1'b0, now_ff} + {1'b0, add_b};
   assign sat_due = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];

   // ------------------------------------------------------------------
   // Head logic: rewrite the tail entry as it passes back into the ring.
   // ------------------------------------------------------------------
   always_comb begin
      head_active = tail_active;
      head_fired  = tail_fired;
      head_key    = tail_key;
      head_period = tail_period;
      head_due    = tail_due;
      shift       = 1'b0;
      hit         = 1'b0;
      fire        = 1'b0;
      inc         = 1'b0;
      dec         = 1'b0;
      emit        = 1'b0;
      case (state_ff)
         ST_SCAN: begin
            shift = 1'b1;
            case (func_ff)
               FUNC_ADD_PERIODIC, FUNC_ADD_ONESHOT: begin
                  // take the lowest free slot
                  if (!found_ff && !tail_active) begin
                     head_active = 1'b1;
                     head_key    = key_ff;
                     head_period = (func_ff == FUNC_ADD_PERIODIC) ? ival_ff : '0;
                     head_due    = sat_due;
                     hit         = 1'b1;
                     inc         = 1'b1;
                  end
               end
               FUNC_DELETE: begin
                  // free the lowest active slot with a matching key
                  if (!found_ff && tail_active && (tail_key == key_ff)) begin
                     head_active = 1'b0;
                     hit         = 1'b1;
                     dec         = 1'b1;
                  end
               end
               FUNC_TICK: begin
                  // mark due entries; rearm those with a nonzero period, drop the others
                  if (tail_active && (tail_due <= now_ff)) begin
                     head_fired = 1'b1;
                     fire       = 1'b1;
                     if (tail_period != '0) begin
                        head_due = sat_due;
                     end else begin
                        head_active = 1'b0;
                        dec         = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_EMIT: begin
            // hold the ring while a marked entry waits for the response register
            if (tail_fired) begin
               if (out_free) begin
                  shift      = 1'b1;
                  head_fired = 1'b0;
                  emit       = 1'b1;
               end
            end else begin
               shift = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer and response loading
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      any_in        = any_ff;
      best_in       = best_ff;
      live_in       = live_ff;
      remain_in     = remain_ff;
      func_in       = func_ff;
      now_in        = now_ff;
      key_in        = key_ff;
      ival_in       = ival_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_due_in    = rsp_due_ff;
      rsp_nv_in     = rsp_nv_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               now_in    = req_now;
               key_in    = req_timer_key;
               ival_in   = req_interval;
               cnt_in    = '0;
               found_in  = 1'b0;
               slot_in   = '0;
               any_in    = 1'b0;
               best_in   = '0;
               remain_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + SLOT_BITS'(1);
            if (hit) begin
               found_in = 1'b1;
               slot_in  = cnt_ff;
            end
            // track the earliest due time of the updated table
            if (head_active && (!any_ff || (head_due < best_ff))) begin
               any_in  = 1'b1;
               best_in = head_due;
            end
            live_in   = live_ff + CNT_BITS'(inc) - CNT_BITS'(dec);
            remain_in = remain_ff + CNT_BITS'(fire);
            if (cnt_ff == LAST_SLOT) begin
               cnt_in = '0;
               if ((func_ff == FUNC_TICK) && ((remain_ff != '0) || fire)) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fired_in = 1'b0;
               rsp_due_in   = any_ff ? best_ff : '0;
               rsp_nv_in    = any_ff;
               rsp_count_in = live_ff;
               rsp_last_in  = 1'b1;
               case (func_ff)
                  FUNC_ADD_PERIODIC, FUNC_ADD_ONESHOT: begin
                     rsp_status_in = found_ff ? STATUS_ADDED : STATUS_FULL;
                     rsp_slot_in   = found_ff ? slot_ff : '0;
                     rsp_key_in    = key_ff;
                  end
                  FUNC_DELETE: begin
                     rsp_status_in = found_ff ? STATUS_DELETED : STATUS_NOT_FOUND;
                     rsp_slot_in   = found_ff ? slot_ff : '0;
                     rsp_key_in    = key_ff;
                  end
                  default: begin
                     // tick with nothing due
                     rsp_status_in = STATUS_TICK;
                     rsp_slot_in   = '0;
                     rsp_key_in    = '0;
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_TICK;
               rsp_fired_in  = 1'b1;
               rsp_slot_in   = cnt_ff;
               rsp_key_in    = tail_key;
               rsp_due_in    = any_ff ? best_ff : '0;
               rsp_nv_in     = any_ff;
               rsp_count_in  = live_ff;
               rsp_last_in   = (remain_ff == CNT_BITS'(1));
               remain_in     = remain_ff - CNT_BITS'(1);
            end
            if (shift) begin
               cnt_in = cnt_ff + SLOT_BITS'(1);
               if (cnt_ff == LAST_SLOT) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         any_ff       <= 1'b0;
         live_ff      <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         any_ff       <= any_in;
         live_ff      <= live_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      best_ff       <= best_in;
      func_ff       <= func_in;
      now_ff        <= now_in;
      key_ff        <= key_in;
      ival_ff       <= ival_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_due_ff    <= rsp_due_in;
      rsp_nv_ff     <= rsp_nv_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_fired_key    = rsp_key_ff;
   assign rsp_next_due     = rsp_due_ff;
   assign rsp_next_valid   = rsp_nv_ff;
   assign rsp_active_count = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `TTSC_ASSERT_NEXT(a_scan_ends, clock, reset, (state_ff == ST_SCAN) && (cnt_ff == LAST_SLOT), (state_ff == ST_EMIT) || (state_ff == ST_DONE), "scan rotation did not end after the last slot")
   `TTSC_ASSERT_NEXT(a_emit_holds, clock, reset, (state_ff == ST_EMIT) && tail_fired && !out_free, $stable(cnt_ff) && (state_ff == ST_EMIT), "ring moved while an expiry word was blocked")
   `TTSC_ASSERT(a_remain_clear, clock, reset, ((state_ff == ST_IDLE) || (state_ff == ST_DONE)) |-> (remain_ff == '0), "expiry words left over outside the emit rotation")
   `TTSC_ASSERT(a_live_bound, clock, reset, live_ff <= CNT_BITS'(ENTRIES), "active count exceeds table size")

endmodule

`default_nettype wire

/* tb/sv/timer_table_scheduler_core_check.sv */
// Response checker for the timer table scheduler core: it mirrors the timer table and
// predicts every response word, then compares the words the core hands out.
// Depends on ttsc_pkg for the operation and status codes.
module timer_table_scheduler_core_check (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  ttsc_pkg::func_type   req_func,
   input  logic [31:0]          req_now,
   input  logic [15:0]          req_timer_key,
   input  logic [31:0]          req_interval,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  ttsc_pkg::status_type rsp_status,
   input  logic                 rsp_fired,
   input  logic [3:0]           rsp_slot_index,
   input  logic [15:0]          rsp_fired_key,
   input  logic [31:0]          rsp_next_due,
   input  logic                 rsp_next_valid,
   input  logic [4:0]           rsp_active_count,
   input  logic                 rsp_last,
   output int                   fail_count,
   output int                   pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import ttsc_pkg::*;

   localparam int SLOTS = 16;

   typedef struct {
      status_type  status;
      logic        fired;
      logic [3:0]  slot;
      logic [15:0] key;
      logic [31:0] next_due;
      logic        next_valid;
      logic [4:0]  count;
      logic        last;
   } timer_word_type;

   // mirror of the timer table
   logic        slot_live   [SLOTS];
   logic [15:0] slot_key    [SLOTS];
   logic [31:0] slot_period [SLOTS];
   logic [31:0] slot_due    [SLOTS];
   int unsigned live_total;

   timer_word_type expected_words[$];

   initial begin
      fail_count    = 0;
      pending_words = 0;
   end

   function automatic logic [31:0] due_sum(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic timer_word_type make_word(input status_type st, input logic fired,
                                                input logic [3:0] slot,
                                                input logic [15:0] key);
      timer_word_type w;
      w = '{status: st, fired: fired, slot: slot, key: key,
            next_due: '0, next_valid: 1'b0, count: '0, last: 1'b0};
      return w;
   endfunction

   // Update the mirror for one request and queue the words it causes.
   task automatic predict_timer_words(input func_type op, input logic [31:0] t,
                                      input logic [15:0] k, input logic [31:0] iv);
      timer_word_type words [SLOTS];
      int             n;
      int             hit;
      int             i;
      logic           any;
      logic [31:0]    best;
      n    = 0;
      hit  = -1;
      any  = 1'b0;
      best = '0;
      case (op)
         FUNC_ADD_PERIODIC, FUNC_ADD_ONESHOT: begin
            for (i = 0; i < SLOTS; i++)
               if (!slot_live[i] && hit < 0) hit = i;
            if (hit >= 0) begin
               slot_live[hit]   = 1'b1;
               slot_key[hit]    = k;
               slot_period[hit] = (op == FUNC_ADD_PERIODIC) ? iv : 32'd0;
               slot_due[hit]    = due_sum(t, iv);
               live_total++;
               words[0] = make_word(STATUS_ADDED, 1'b0, hit[3:0], k);
            end else begin
               words[0] = make_word(STATUS_FULL, 1'b0, 4'd0, k);
            end
            n = 1;
         end
         FUNC_DELETE: begin
            for (i = 0; i < SLOTS; i++)
               if (slot_live[i] && slot_key[i] == k && hit < 0) hit = i;
            if (hit >= 0) begin
               slot_live[hit] = 1'b0;
               live_total--;
               words[0] = make_word(STATUS_DELETED, 1'b0, hit[3:0], k);
            end else begin
               words[0] = make_word(STATUS_NOT_FOUND, 1'b0, 4'd0, k);
            end
            n = 1;
         end
         default: begin
            for (i = 0; i < SLOTS; i++) begin
               if (slot_live[i] && slot_due[i] <= t) begin
                  words[n] = make_word(STATUS_TICK, 1'b1, i[3:0], slot_key[i]);
                  n++;
                  if (slot_period[i] != 0) begin
                     slot_due[i] = due_sum(t, slot_period[i]);
                  end else begin
                     slot_live[i] = 1'b0;
                     live_total--;
                  end
               end
            end
            if (n == 0) begin
               words[0] = make_word(STATUS_TICK, 1'b0, 4'd0, 16'd0);
               n = 1;
            end
         end
      endcase
      for (i = 0; i < SLOTS; i++) begin
         if (slot_live[i] && (!any || slot_due[i] < best)) begin
            best = slot_due[i];
            any  = 1'b1;
         end
      end
      for (i = 0; i < n; i++) begin
         words[i].next_due   = any ? best : 32'd0;
         words[i].next_valid = any;
         words[i].count      = live_total[4:0];
         words[i].last       = (i == n - 1);
         expected_words.push_back(words[i]);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < 40)
         $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      timer_word_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
         live_total = 0;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected response word, status", 32'(rsp_status), 32'd0);
            end else begin
               want = expected_words.pop_front();
               check_field("status",       32'(rsp_status),       32'(want.status));
               check_field("fired",        32'(rsp_fired),        32'(want.fired));
               check_field("slot_index",   32'(rsp_slot_index),   32'(want.slot));
               check_field("fired_key",    32'(rsp_fired_key),    32'(want.key));
               check_field("next_due",     rsp_next_due,          want.next_due);
               check_field("next_valid",   32'(rsp_next_valid),   32'(want.next_valid));
               check_field("active_count", 32'(rsp_active_count), 32'(want.count));
               check_field("last",         32'(rsp_last),         32'(want.last));
            end
         end
         if (req_valid && !req_stall)
            predict_timer_words(req_func, req_now, req_timer_key, req_interval);
      end
      pending_words <= expected_words.size();
   end

endmodule

/* tb/sv/timer_table_scheduler_core_tb.sv */
// Testbench top for the timer table scheduler core: clock, reset, request stimulus,
// response stall pattern and the verdict. Depends on ttsc_pkg, the core and its checker.
module timer_table_scheduler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ttsc_pkg::*;

   localparam int RANDOM_WORDS = 135;
   // a firing tick makes a scan rotation and an emit rotation; leave room for a stray word after that
   localparam int DRAIN_CYCLES = 2 * 16 + 32;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid     = 1'b0;
   logic        req_stall;
   func_type    req_func      = FUNC_TICK;
   logic [31:0] req_now       = '0;
   logic [15:0] req_timer_key = '0;
   logic [31:0] req_interval  = '0;

   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   status_type  rsp_status;
   logic        rsp_fired;
   logic [3:0]  rsp_slot_index;
   logic [15:0] rsp_fired_key;
   logic [31:0] rsp_next_due;
   logic        rsp_next_valid;
   logic [4:0]  rsp_active_count;
   logic        rsp_last;

   int          fail_count;
   int          pending_words;

   // knobs the stimulus sets for the response process and for the request sender
   int unsigned stall_request = 0;   // one long hold for the response side
   int unsigned sender_calm   = 0;   // words still to offer without gaps

   logic [15:0] key_pool [6];
   logic [31:0] clock_now;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   timer_table_scheduler_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_now          (req_now),
      .req_timer_key    (req_timer_key),
      .req_interval     (req_interval),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_fired        (rsp_fired),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_fired_key    (rsp_fired_key),
      .rsp_next_due     (rsp_next_due),
      .rsp_next_valid   (rsp_next_valid),
      .rsp_active_count (rsp_active_count),
      .rsp_last         (rsp_last)
   );

   timer_table_scheduler_core_check u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_now          (req_now),
      .req_timer_key    (req_timer_key),
      .req_interval     (req_interval),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_fired        (rsp_fired),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_fired_key    (rsp_fired_key),
      .rsp_next_due     (rsp_next_due),
      .rsp_next_valid   (rsp_next_valid),
      .rsp_active_count (rsp_active_count),
      .rsp_last         (rsp_last),
      .fail_count       (fail_count),
      .pending_words    (pending_words)
   );

   // Offer one request word and hold it until the core takes it.
   // Valid is only lowered when a gap follows, so back-to-back words keep it high.
   task automatic offer_word(input func_type op, input logic [31:0] t,
                             input logic [15:0] k, input logic [31:0] iv);
      int unsigned gap;
      if (sender_calm != 0) begin
         gap = 0;
         sender_calm--;
      end else if ($urandom_range(0, 24) == 0) begin
         gap = 0;
         sender_calm = 20;
      end else begin
         gap = $urandom_range(0, 16);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= op;
      req_now       <= t;
      req_timer_key <= k;
      req_interval  <= iv;
      // hold the payload steady while the core stalls
      do @(posedge clock); while (req_stall);
   endtask

   // Response side: draw a hold for every word, with calm stretches and one long hold.
   initial begin : response_sink
      int unsigned hold;
      int unsigned calm_left;
      calm_left = 0;
      forever begin
         if (stall_request != 0) begin
            hold = stall_request;
            stall_request = 0;
         end else if (calm_left != 0) begin
            hold = 0;
            calm_left--;
         end else if ($urandom_range(0, 29) == 0) begin
            hold = 0;
            calm_left = 30;
         end else begin
            hold = $urandom_range(0, 16);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         // wait until a word goes through with stall low
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Guard against a hung core: far beyond the slowest correct run.
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      func_type    op;
      logic [15:0] k;
      logic [31:0] iv;
      int          i;
      int unsigned pick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // tick and delete on an empty table
      offer_word(FUNC_TICK,         32'd0,         16'h0000, 32'd0);
      offer_word(FUNC_DELETE,       32'd0,         16'h1234, 32'hFFFF_FFFF);
      // saturating due time, zero interval at the largest time
      offer_word(FUNC_ADD_PERIODIC, 32'd5,         16'hFFFF, 32'hFFFF_FFFF);
      offer_word(FUNC_ADD_ONESHOT,  32'hFFFF_FFFF, 16'h0000, 32'd0);
      offer_word(FUNC_ADD_PERIODIC, 32'd100,       16'hAAAA, 32'd10);
      offer_word(FUNC_ADD_ONESHOT,  32'd100,       16'h5555, 32'd5);
      // tick with entries live but none due, then one that fires both
      offer_word(FUNC_TICK,         32'd104,       16'h0000, 32'd0);
      offer_word(FUNC_TICK,         32'd110,       16'hFFFF, 32'd0);
      // delete the rearmed periodic entry, then miss on the same key
      offer_word(FUNC_DELETE,       32'd111,       16'hAAAA, 32'd0);
      offer_word(FUNC_DELETE,       32'd111,       16'hAAAA, 32'd0);
      // fill the table with repeated keys and a zero-period periodic add
      for (i = 0; i < 14; i++) begin
         op = (i % 3 == 0) ? FUNC_ADD_ONESHOT : FUNC_ADD_PERIODIC;
         offer_word(op, 32'd200, 16'h0100 + 16'(i % 4), (i == 5) ? 32'd0 : 32'(i + 1));
      end
      offer_word(FUNC_ADD_PERIODIC, 32'd200,       16'hBEEF, 32'd7);
      // every slot expires at once: the longest burst of expiry words
      offer_word(FUNC_TICK,         32'hFFFF_FFFF, 16'h0000, 32'd0);
      // lowest of the duplicate keys goes first
      offer_word(FUNC_DELETE,       32'd300,       16'h0101, 32'd0);

      // --- random part ---
      for (i = 0; i < 6; i++) key_pool[i] = 16'($urandom);
      clock_now = 32'd1000;
      for (i = 0; i < RANDOM_WORDS; i++) begin
         // at word 60: stop reading responses for a while and keep offering requests
         if (i == 60) begin
            stall_request = 320;
            sender_calm   = 14;
         end

         // advance time mostly in small steps, sometimes jump near the top or anywhere
         pick = $urandom_range(0, 19);
         if (pick == 0)      clock_now = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
         else if (pick == 1) clock_now = $urandom;
         else                clock_now = clock_now + 32'($urandom_range(0, 12));

         pick = $urandom_range(0, 9);
         if (pick == 0)      iv = 32'd0;
         else if (pick == 1) iv = $urandom;
         else if (pick == 2) iv = 32'hFFFF_FFFF;
         else                iv = 32'($urandom_range(1, 40));

         k = ($urandom_range(0, 3) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 5)];

         pick = $urandom_range(0, 19);
         if (pick < 6)       op = FUNC_ADD_PERIODIC;
         else if (pick < 9)  op = FUNC_ADD_ONESHOT;
         else if (pick < 15) op = FUNC_DELETE;
         else                op = FUNC_TICK;

         offer_word(op, clock_now, k, iv);
      end
      req_valid <= 1'b0;

      // drain: let the checker see the last accepted word, then wait for every response
      repeat (2) @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
